// ===== rtl/bffa_pkg.sv =====
package bffa_pkg;

  typedef struct packed {
    logic        operation;
    logic [20:0] byte_size;
    logic [7:0]  start_index;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic [7:0] block_index;
  } rsp_t;

  typedef struct packed {
    logic [3:0] block_size_log2;
    logic [8:0] active_blocks;
  } cfg_t;

  typedef enum logic [0:0] {
    REG_BLOCK_SIZE_LOG2 = 1'b0,
    REG_ACTIVE_BLOCKS   = 1'b1
  } reg_e;

  localparam logic       OP_ALLOCATE  = 1'b0;
  localparam logic       OP_FREE      = 1'b1;
  localparam logic [3:0] LOG2_MAX     = 4'd12;
  localparam logic [3:0] LOG2_RESET   = 4'd6;
  localparam logic [8:0] ACTIVE_RESET = 9'd256;
  localparam int         WORD_BITS    = 8;
  localparam int         WORD_SHIFT   = 3;

endpackage

// ===== rtl/bffa_regs.sv =====
module bffa_regs import bffa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e sel;

  assign sel    = reg_e'(paddr[2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (sel)
        REG_BLOCK_SIZE_LOG2: cfg_d.block_size_log2 = pwdata[3:0];
        REG_ACTIVE_BLOCKS:   cfg_d.active_blocks   = pwdata[8:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_BLOCK_SIZE_LOG2: prdata = {28'd0, cfg_q.block_size_log2};
      REG_ACTIVE_BLOCKS:   prdata = {23'd0, cfg_q.active_blocks};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_size_log2 <= LOG2_RESET;
      cfg_q.active_blocks   <= ACTIVE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/bitmap_first_fit_allocator.sv =====
// First-fit block allocator over a used-bit map held in a memory of 8-bit words. It takes
// one request word at a time and returns exactly one response word. The map lives in a
// single memory with one read and one write port, and that memory sets the pace: an allocate
// scans map words one by one (at most ceil(active_blocks/8) of them) until a fitting run is
// found, then marks the words the run covers by read-modify-write; a free clears the words
// of its run by read-modify-write, and a zero-size request needs no map access. After reset
// a clearing pass writes every map word, and no request is taken until it ends; register
// writes are taken throughout. Register writes are allowed only while the allocator is idle.
module bitmap_first_fit_allocator import bffa_pkg::*; #(
  parameter int MAP_BLOCKS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NW  = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
  localparam int GW  = AW + WORD_SHIFT;
  localparam int CW  = $clog2(MAP_BLOCKS + 2);
  localparam int XW0 = (CW > GW) ? CW : GW;
  localparam int XW  = ((XW0 > 8) ? XW0 : 8) + 1;

  localparam logic [XW-1:0] MAP_X     = XW'(MAP_BLOCKS);
  localparam logic [XW-1:0] NEED_OVER = XW'(MAP_BLOCKS + 1);
  localparam logic [AW-1:0] LAST_WORD = AW'(NW - 1);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_CALC   = 8'b0000_0100,
    ST_DECIDE = 8'b0000_1000,
    ST_SCAN   = 8'b0001_0000,
    ST_READ   = 8'b0010_0000,
    ST_WRITE  = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_e;

  cfg_t cfg;

  bffa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e state_q, state_d;
  logic [AW-1:0] wptr_q, wptr_d;
  logic [AW-1:0] ip_q, ip_d;
  logic [AW-1:0] ep_q, ep_d;
  logic          iss_done_q, iss_done_d;
  logic          rvld_q, rvld_d;
  logic          out_valid_q, out_valid_d;

  req_t          req_q, req_d;
  logic [XW-1:0] need_q, need_d;
  logic [XW-1:0] lo_q, lo_d;
  logic [XW-1:0] hi_q, hi_d;
  logic [XW-1:0] run_len_q, run_len_d;
  logic [XW-1:0] run_start_q, run_start_d;
  rsp_t          res_q, res_d;
  rsp_t          out_word_q, out_word_d;

  logic [WORD_BITS-1:0] map_mem [NW];
  logic [WORD_BITS-1:0] rdata_q;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] wmask;
  logic [AW-1:0]        raddr;
  logic                 mem_we;

  logic [XW-1:0] act_x;
  logic [3:0]    shamt;
  logic [21:0]   rounded;
  logic [XW-1:0] need_x;
  logic [XW-1:0] free_sum;
  logic [XW-1:0] free_hi;
  logic [XW-1:0] start_x;
  logic          ip_last;
  logic          ep_last;
  logic          wr_last;
  logic [XW-1:0] scan_len;
  logic [XW-1:0] scan_start;
  logic          scan_found;
  logic [XW-1:0] g;
  logic [XW-1:0] gm;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign act_x   = (XW'(cfg.active_blocks) > MAP_X) ? MAP_X : XW'(cfg.active_blocks);
  assign shamt   = (cfg.block_size_log2 > LOG2_MAX) ? LOG2_MAX : cfg.block_size_log2;
  assign rounded = (22'(req_q.byte_size) + ((22'd1 << shamt) - 22'd1)) >> shamt;
  assign need_x  = (rounded > 22'(MAP_BLOCKS)) ? NEED_OVER : XW'(rounded);

  assign start_x  = XW'(req_q.start_index);
  assign free_sum = start_x + need_q;
  assign free_hi  = (free_sum > act_x) ? act_x : free_sum;

  assign ip_last = ((XW'(ip_q) + XW'(1)) << WORD_SHIFT) >= act_x;
  assign ep_last = ((XW'(ep_q) + XW'(1)) << WORD_SHIFT) >= act_x;
  assign wr_last = ((XW'(wptr_q) + XW'(1)) << WORD_SHIFT) >= hi_q;

  assign raddr = (state_q == ST_SCAN) ? ip_q : wptr_q;

  // Walk the eight bits of the fetched word, carrying the free run across words.
  always_comb begin
    scan_len   = run_len_q;
    scan_start = run_start_q;
    scan_found = 1'b0;
    g          = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      g = XW'({ep_q, WORD_SHIFT'(b)});
      if (!scan_found) begin
        if (!rdata_q[b] && (g < act_x)) begin
          if (scan_len == '0) begin
            scan_start = g;
          end
          scan_len = scan_len + XW'(1);
          if (scan_len == need_q) begin
            scan_found = 1'b1;
          end
        end else begin
          scan_len = '0;
        end
      end
    end
  end

  always_comb begin
    wmask = '0;
    gm    = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      gm       = XW'({wptr_q, WORD_SHIFT'(b)});
      wmask[b] = (gm >= lo_q) && (gm < hi_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    wptr_d      = wptr_q;
    ip_d        = ip_q;
    ep_d        = ep_q;
    iss_done_d  = iss_done_q;
    rvld_d      = 1'b0;
    req_d       = req_q;
    need_d      = need_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    run_len_d   = run_len_q;
    run_start_d = run_start_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    wdata       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (wptr_q == LAST_WORD) begin
          wptr_d  = '0;
          state_d = ST_IDLE;
        end else begin
          wptr_d = wptr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_word_i;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        need_d  = need_x;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (req_q.operation == OP_ALLOCATE) begin
          if (need_q == '0) begin
            res_d   = '{granted: 1'b1, block_index: 8'd0};
            state_d = ST_FINISH;
          end else if (need_q > act_x) begin
            res_d   = '{granted: 1'b0, block_index: 8'd0};
            state_d = ST_FINISH;
          end else begin
            ip_d        = '0;
            ep_d        = '0;
            iss_done_d  = 1'b0;
            run_len_d   = '0;
            run_start_d = '0;
            state_d     = ST_SCAN;
          end
        end else begin
          res_d = '{granted: 1'b1, block_index: req_q.start_index};
          if (start_x >= free_hi) begin
            state_d = ST_FINISH;
          end else begin
            lo_d    = start_x;
            hi_d    = free_hi;
            wptr_d  = start_x[GW-1:WORD_SHIFT];
            state_d = ST_READ;
          end
        end
      end
      ST_SCAN: begin
        if (!iss_done_q) begin
          rvld_d = 1'b1;
          if (ip_last) begin
            iss_done_d = 1'b1;
          end else begin
            ip_d = ip_q + AW'(1);
          end
        end
        if (rvld_q) begin
          run_len_d   = scan_len;
          run_start_d = scan_start;
          ep_d        = ep_q + AW'(1);
          if (scan_found) begin
            lo_d    = scan_start;
            hi_d    = scan_start + need_q;
            wptr_d  = scan_start[GW-1:WORD_SHIFT];
            res_d   = '{granted: 1'b1, block_index: scan_start[7:0]};
            rvld_d  = 1'b0;
            state_d = ST_READ;
          end else if (ep_last) begin
            res_d   = '{granted: 1'b0, block_index: 8'd0};
            rvld_d  = 1'b0;
            state_d = ST_FINISH;
          end
        end
      end
      ST_READ: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        mem_we = 1'b1;
        wdata  = (req_q.operation == OP_FREE) ? (rdata_q & ~wmask) : (rdata_q | wmask);
        if (wr_last) begin
          state_d = ST_FINISH;
        end else begin
          wptr_d  = wptr_q + AW'(1);
          state_d = ST_READ;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_word_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[wptr_q] <= wdata;
    end
    rdata_q <= map_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      wptr_q      <= '0;
      ip_q        <= '0;
      ep_q        <= '0;
      iss_done_q  <= 1'b0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      ip_q        <= ip_d;
      ep_q        <= ep_d;
      iss_done_q  <= iss_done_d;
      rvld_q      <= rvld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    need_q      <= need_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    run_len_q   <= run_len_d;
    run_start_q <= run_start_d;
    res_q       <= res_d;
    out_word_q  <= out_word_d;
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("allocator took a second word while busy");

  a_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> ((lo_q < hi_q) && (hi_q <= act_x)))
    else $error("run to update lies outside the active blocks");

  a_write_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (wptr_q <= LAST_WORD))
    else $error("map write beyond the last word");

  a_fail_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.granted) |-> (out_word_o.block_index == 8'd0))
    else $error("failed allocation reports a nonzero index");
`endif

endmodule

// ===== test/bitmap_first_fit_allocator_tb.sv =====
module bitmap_first_fit_allocator_tb;
  import bffa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_BLOCKS = 256;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PER_PHASE = 146;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_word;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the allocator: its block map and its two registers.
  bit          block_used [MAP_BLOCKS];
  logic [3:0]  cfg_log2 = LOG2_RESET;
  logic [8:0]  cfg_active = ACTIVE_RESET;

  req_t        requests_todo [$];
  rsp_t        grants_due [$];
  rsp_t        due;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  bitmap_first_fit_allocator #(
    .MAP_BLOCKS(MAP_BLOCKS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  function automatic int unsigned eff_log2();
    return (cfg_log2 > LOG2_MAX) ? 32'(LOG2_MAX) : 32'(cfg_log2);
  endfunction

  function automatic int unsigned eff_active();
    return (32'(cfg_active) > MAP_BLOCKS) ? MAP_BLOCKS : 32'(cfg_active);
  endfunction

  // Works out the response to one request and applies it to the shadow map.
  function automatic rsp_t grant_for(req_t w);
    int unsigned s;
    int unsigned act;
    int unsigned need;
    int unsigned stop;
    bit fits;
    rsp_t r;
    s = eff_log2();
    act = eff_active();
    need = (int'(w.byte_size) + (32'd1 << s) - 1) >> s;
    r.granted = 1'b1;
    r.block_index = w.start_index;
    if (w.operation == OP_ALLOCATE) begin
      r.block_index = '0;
      if (need != 0) begin
        r.granted = 1'b0;
        if (need <= act) begin
          for (int unsigned i = 0; i + need <= act; i++) begin
            fits = 1'b1;
            for (int unsigned j = 0; j < need; j++) begin
              if (block_used[i + j]) begin
                fits = 1'b0;
                break;
              end
            end
            if (fits) begin
              for (int unsigned j = 0; j < need; j++) block_used[i + j] = 1'b1;
              r.granted = 1'b1;
              r.block_index = i[7:0];
              break;
            end
          end
        end
      end
    end else begin
      stop = int'(w.start_index) + need;
      if (stop > act) stop = act;
      for (int unsigned k = int'(w.start_index); k < stop; k++) block_used[k] = 1'b0;
    end
    return r;
  endfunction

  // A byte count that rounds up to exactly n blocks.
  function automatic logic [20:0] bytes_spanning(int unsigned n, int unsigned s);
    int unsigned b;
    b = n << s;
    if (n != 0) b = b - $urandom_range((32'd1 << s) - 1);
    return b[20:0];
  endfunction

  task automatic queue_word(logic op, logic [20:0] bytes, logic [7:0] start);
    req_t w;
    w.operation = op;
    w.byte_size = bytes;
    w.start_index = start;
    requests_todo.push_back(w);
  endtask

  task automatic queue_requests(int unsigned count);
    int unsigned s;
    int unsigned act;
    int unsigned pick;
    int unsigned span;
    req_t w;
    s = eff_log2();
    act = eff_active();
    for (int unsigned c = 0; c < count; c++) begin
      pick = $urandom_range(99);
      span = $urandom_range(99);
      w.start_index = 8'($urandom);
      w.operation = (pick < 55) ? OP_ALLOCATE : OP_FREE;
      if (span < 3) begin
        w.byte_size = 21'($urandom);
      end else if (span < 9) begin
        w.byte_size = bytes_spanning($urandom_range(act + 2), s);
      end else begin
        w.byte_size = bytes_spanning($urandom_range(w.operation == OP_FREE ? 16 : 8), s);
      end
      if (w.operation == OP_FREE) begin
        if (pick < 58) begin
          w.start_index = '0;
          w.byte_size = '1;
        end else if (pick < 95) begin
          w.start_index = 8'($urandom_range((act > 0) ? act - 1 : 0));
        end
      end
      requests_todo.push_back(w);
    end
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_BLOCK_SIZE_LOG2) cfg_log2 = value[3:0];
    else cfg_active = value[8:0];
  endtask

  task automatic wait_idle();
    while (requests_todo.size() != 0 || in_valid || grants_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) grants_due.push_back(grant_for(in_word));
      if (!in_valid || in_ready) begin
        if (requests_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_word <= requests_todo.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (grants_due.size() == 0) begin
        $error("Response word arrived with no request outstanding.");
        mismatches++;
      end else begin
        due = grants_due.pop_front();
        if (out_word.granted !== due.granted) begin
          $error("granted: expected %0d, got %0d", due.granted, out_word.granted);
          mismatches++;
        end
        if (out_word.block_index !== due.block_index) begin
          $error("block_index: expected %0d, got %0d", due.block_index, out_word.block_index);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned log2_plan [9] = '{0, 12, 15, 3, 13, 5, 4, 2, 1};
    int unsigned active_plan [9] = '{8, 256, 511, 0, 1, 64, 100, 300, 37};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the reset register values.
    queue_word(OP_ALLOCATE, 21'd0, 8'd255);
    queue_word(OP_ALLOCATE, 21'd1, 8'd0);
    queue_word(OP_ALLOCATE, 21'd64, 8'd0);
    queue_word(OP_ALLOCATE, 21'd65, 8'd0);
    queue_word(OP_FREE, 21'd64, 8'd1);
    queue_word(OP_ALLOCATE, 21'd63, 8'd0);
    queue_word(OP_FREE, 21'd0, 8'd255);
    queue_word(OP_ALLOCATE, 21'h1FFFFF, 8'd0);
    queue_word(OP_ALLOCATE, 21'd1048576, 8'd0);
    queue_word(OP_ALLOCATE, 21'd16384, 8'd0);
    queue_word(OP_FREE, 21'h1FFFFF, 8'd0);
    queue_word(OP_ALLOCATE, 21'd16384, 8'd0);
    queue_word(OP_ALLOCATE, 21'd1, 8'd0);
    queue_word(OP_FREE, 21'd64, 8'd255);
    queue_word(OP_ALLOCATE, 21'd1, 8'd0);
    queue_word(OP_FREE, 21'd1048576, 8'd200);
    queue_word(OP_ALLOCATE, 21'd3584, 8'd0);
    queue_word(OP_FREE, 21'h1FFFFF, 8'd0);

    for (int unsigned p = 0; p < 12; p++) begin
      wait_idle();
      if (p < 9) begin
        write_reg(REG_BLOCK_SIZE_LOG2, log2_plan[p]);
        write_reg(REG_ACTIVE_BLOCKS, active_plan[p]);
      end else begin
        write_reg(REG_BLOCK_SIZE_LOG2, $urandom_range(15));
        write_reg(REG_ACTIVE_BLOCKS, $urandom_range(511));
      end
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 51;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 51;
        end
        default: begin
          send_idle_pct = 21;
          recv_stall_pct = 21;
        end
      endcase
      queue_requests(PER_PHASE);
    end

    wait_idle();
    repeat (150) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
